@@ rtl/i2cmbw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbw_pkg
// Shared widths, command codes and the queued command type of the i2c byte
// writer.
// ----------------------------------------------------------------------------
package i2cmbw_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int BIT_CNT_W   = $clog2(BYTE_BITS + 1);
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;

   // command codes carried on req_tuser
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_ADDR  = 2'd1;
   localparam logic [1:0] MODE_DATA  = 2'd2;
   localparam logic [1:0] MODE_STOP  = 2'd3;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_BYTE,
      KIND_STOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [BYTE_BITS-1:0] bits;
      logic                 ack;
   } cmd_type;

endpackage

@@ rtl/i2c_master_byte_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_writer
// Open-drain i2c master transmitter: start, address byte, data byte and stop
// commands in, one bus phase per transfer out.
// ----------------------------------------------------------------------------
//   channel  dir  tdata                                  tuser        tlast
//   req_     in   [7:0] data_byte [8] read_write [9] ack mode [1:0]   -
//   rsp_     out  [0] scl_level [1] sda_pull_low         nack_error   last_phase
//
// start and stop have 3 phases, address and data bytes 27: the sequencer emits
// one bus phase per cycle unless rsp_ stalls, and commands follow back to back.
// a two-entry queue and a front register let up to three commands wait.
// synchronous active-high reset releases scl high and sda, empties the queue.
// rsp_ stalls hold the sequencer; req_ stalls only once the queue fills.
// ----------------------------------------------------------------------------
module i2c_master_byte_writer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [i2cmbw_pkg::REQ_TDATA_W-1:0] req_tdata,  // data_byte, read_write, ack_level
   input  logic [1:0]                         req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [i2cmbw_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // scl_level, sda_pull_low
   output logic                               rsp_tuser,  // nack_error
   output logic                               rsp_tlast   // last_phase
);
   import i2cmbw_pkg::*;

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    head_valid;
   logic    head_ready;
   cmd_type head_cmd;

   i2cmbw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd        (front_cmd),
      .cmd_ready  (front_ready)
   );

   i2cmbw_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_data   (head_cmd)
   );

   i2cmbw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head       (head_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/i2cmbw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbw_front
// Accepts commands, forms the address byte and registers one classified
// command for the queue.
// ----------------------------------------------------------------------------
module i2cmbw_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [i2cmbw_pkg::REQ_TDATA_W-1:0] req_tdata,  // data_byte, read_write, ack_level
   input  logic [1:0]                         req_tuser,  // mode
   output logic                               cmd_valid,
   output i2cmbw_pkg::cmd_type                cmd,
   input  logic                               cmd_ready
);
   import i2cmbw_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    take;

   always_comb begin
      cmd_in.bits = req_tdata[BYTE_BITS-1:0];
      cmd_in.ack  = req_tdata[BYTE_BITS+1];
      unique case (req_tuser)
         MODE_START: begin
            cmd_in.kind = KIND_START;
         end
         MODE_ADDR: begin
            // direction bit replaces the low address bit
            cmd_in.kind = KIND_BYTE;
            cmd_in.bits = {req_tdata[BYTE_BITS-1:1], req_tdata[BYTE_BITS]};
         end
         MODE_DATA: begin
            cmd_in.kind = KIND_BYTE;
         end
         MODE_STOP: begin
            cmd_in.kind = KIND_STOP;
         end
         default: begin
            cmd_in.kind = KIND_STOP;
         end
      endcase
   end

   assign req_tready = !valid_ff || cmd_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

@@ rtl/i2cmbw_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbw_fifo
// Short command queue between the front end and the bus sequencer.
// ----------------------------------------------------------------------------
module i2cmbw_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  i2cmbw_pkg::cmd_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output i2cmbw_pkg::cmd_type pop_data
);
   import i2cmbw_pkg::*;

   cmd_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/i2cmbw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbw_back
// Bus phase sequencer: walks each command through its phases, one phase per
// cycle unless the result side stalls, and keeps the current line levels.
// ----------------------------------------------------------------------------
module i2cmbw_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   output logic                               head_ready,
   input  i2cmbw_pkg::cmd_type                head,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [i2cmbw_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // scl_level, sda_pull_low
   output logic                               rsp_tuser,  // nack_error
   output logic                               rsp_tlast   // last_phase
);
   import i2cmbw_pkg::*;

   typedef enum logic [1:0] {
      STEP_SET,
      STEP_RISE,
      STEP_FALL
   } step_type;

   logic                 busy_ff;
   step_type             step_ff;
   logic [BIT_CNT_W-1:0] bit_ff;
   cmd_type              held_ff;
   logic [BYTE_BITS-1:0] shreg_ff;
   logic                 scl_ff;
   logic                 sda_ff;
   logic                 out_valid_ff;
   logic                 out_scl_ff;
   logic                 out_sda_ff;
   logic                 out_nack_ff;
   logic                 out_last_ff;

   cmd_type              cur;
   step_type             step;
   step_type             step_in;
   logic [BIT_CNT_W-1:0] bitn;
   logic [BIT_CNT_W-1:0] bit_in;
   logic [BYTE_BITS-1:0] work;
   logic [BYTE_BITS-1:0] shreg_in;
   logic                 scl_in;
   logic                 sda_in;
   logic                 last;
   logic                 nack;
   logic                 have;
   logic                 go;
   logic                 ack_bit;

   always_comb begin
      cur     = busy_ff ? held_ff : head;
      step    = busy_ff ? step_ff : STEP_SET;
      bitn    = busy_ff ? bit_ff : '0;
      work    = busy_ff ? shreg_ff : head.bits;
      have    = busy_ff || head_valid;
      go      = have && (!out_valid_ff || rsp_tready);
      ack_bit = (bitn == BIT_CNT_W'(BYTE_BITS));
   end

   assign head_ready = go && !busy_ff;

   always_comb begin
      scl_in = scl_ff;
      sda_in = sda_ff;
      last   = 1'b0;
      nack   = 1'b0;
      unique case (cur.kind)
         KIND_START: begin
            unique case (step)
               STEP_SET:  scl_in = 1'b1;
               STEP_RISE: sda_in = 1'b1;
               STEP_FALL: begin
                  scl_in = 1'b0;
                  last   = 1'b1;
               end
               default: ;
            endcase
         end
         KIND_BYTE: begin
            unique case (step)
               // acknowledge slot releases sda, data bits pull low on a zero
               STEP_SET:  sda_in = ack_bit ? 1'b0 : !work[BYTE_BITS-1];
               STEP_RISE: scl_in = 1'b1;
               STEP_FALL: begin
                  scl_in = 1'b0;
                  last   = ack_bit;
                  nack   = ack_bit && cur.ack;
               end
               default: ;
            endcase
         end
         KIND_STOP: begin
            unique case (step)
               STEP_SET:  sda_in = 1'b1;
               STEP_RISE: scl_in = 1'b1;
               STEP_FALL: begin
                  sda_in = 1'b0;
                  last   = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      step_in  = STEP_SET;
      bit_in   = bitn;
      shreg_in = work;
      unique case (step)
         STEP_SET:  step_in = STEP_RISE;
         STEP_RISE: step_in = STEP_FALL;
         STEP_FALL: begin
            step_in  = STEP_SET;
            bit_in   = bitn + 1'b1;
            shreg_in = {work[BYTE_BITS-2:0], 1'b0};
         end
         default: step_in = STEP_SET;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_SET;
         bit_ff       <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         out_scl_ff   <= 1'b1;
         out_sda_ff   <= 1'b0;
         out_nack_ff  <= 1'b0;
         out_last_ff  <= 1'b0;
      end else if (go) begin
         busy_ff      <= !last;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         out_valid_ff <= 1'b1;
         out_scl_ff   <= scl_in;
         out_sda_ff   <= sda_in;
         out_nack_ff  <= nack;
         out_last_ff  <= last;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         held_ff  <= cur;
         shreg_ff <= shreg_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2){1'b0}}, out_sda_ff, out_scl_ff};
   assign rsp_tuser  = out_nack_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ rtl/i2cmbw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbw_checker
// Port-level checks on the bus phase stream of the i2c byte writer.
// ----------------------------------------------------------------------------
module i2cmbw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [i2cmbw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);

   // nothing to show right after reset
   property p_idle_after_reset;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty
   a_idle_after_reset: assert property (p_idle_after_reset)
      else $error("phase shown right after reset");

   // a stalled phase holds its levels
   property p_stall_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast);
   endproperty
   a_stall_hold: assert property (p_stall_hold)
      else $error("stalled phase changed");

   // a nack only comes on the closing phase of a byte
   property p_nack_on_last;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tuser |-> rsp_tlast && !rsp_tdata[0];
   endproperty
   a_nack_on_last: assert property (p_nack_on_last)
      else $error("nack outside the closing phase of a byte");

   // every command ends with scl low, or after a stop with sda released
   property p_clean_end;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tlast |-> !rsp_tdata[0] || !rsp_tdata[1];
   endproperty
   a_clean_end: assert property (p_clean_end)
      else $error("command ended with scl high and sda pulled low");

endmodule

bind i2c_master_byte_writer i2cmbw_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the i2c master byte writer. A directed table and
// then random start / address / data / stop transactions are sent with
// bursty timing while the result side stalls on its own pattern. Each bus
// phase that comes out is compared against a line-level model of the
// open-drain sequencer kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
   import i2cmbw_pkg::*;

   localparam int CLK_HALF_NS  = 4;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 114;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 40;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int PAD_W        = REQ_TDATA_W - 10;
   localparam int NUM_ROWS     = 16;

   typedef struct packed {
      logic scl;
      logic sda;
      logic nack;
      logic last;
   } bus_phase_type;

   // t_* give the final phase of the command where it is known up front
   typedef struct packed {
      logic [1:0]       mode;
      logic [7:0]       data_val;
      logic             rw;
      logic             ack;
      logic [PAD_W-1:0] pad;
      logic             typed;
      logic             t_scl;
      logic             t_sda;
      logic             t_nack;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // data_byte, read_write, ack_level
   logic [1:0]             req_tuser;   // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // scl_level, sda_pull_low
   logic                   rsp_tuser;   // nack_error
   logic                   rsp_tlast;   // last_phase

   // line levels as the bus master should leave them
   logic          line_scl;
   logic          line_sda;
   bus_phase_type expected_phases[$];

   int  mismatch_count;
   int  phases_checked;
   int  cmds_sent;
   int  mode_count[4];
   int  nack_count;
   int  burst_left;
   int  no_gap_left;
   bit  long_hold_req;

   stim_row_type directed_rows [NUM_ROWS] = '{
      // start right after reset: scl ends low with sda pulled low
      '{MODE_START, 8'h00, 1'b0, 1'b0, 6'h00, 1'b1, 1'b0, 1'b1, 1'b0},
      '{MODE_ADDR,  8'hFF, 1'b0, 1'b0, 6'h00, 1'b1, 1'b0, 1'b0, 1'b0},
      '{MODE_DATA,  8'h00, 1'b0, 1'b1, 6'h00, 1'b1, 1'b0, 1'b0, 1'b1},
      '{MODE_DATA,  8'hFF, 1'b1, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{MODE_DATA,  8'hA5, 1'b0, 1'b1, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      // stop leaves scl high and sda released
      '{MODE_STOP,  8'h00, 1'b0, 1'b0, 6'h00, 1'b1, 1'b1, 1'b0, 1'b0},
      '{MODE_ADDR,  8'h00, 1'b1, 1'b1, 6'h00, 1'b1, 1'b0, 1'b0, 1'b1},
      '{MODE_STOP,  8'hFF, 1'b1, 1'b1, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{MODE_STOP,  8'h00, 1'b0, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{MODE_START, 8'hFF, 1'b1, 1'b1, 6'h3F, 1'b0, 1'b0, 1'b0, 1'b0},
      // repeated start with no stop in between
      '{MODE_START, 8'h00, 1'b0, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      // bits above the packed fields must be ignored
      '{MODE_DATA,  8'h5A, 1'b1, 1'b0, 6'h3F, 1'b0, 1'b0, 1'b0, 1'b0},
      '{MODE_ADDR,  8'h81, 1'b1, 1'b0, 6'h2A, 1'b0, 1'b0, 1'b0, 1'b0},
      '{MODE_DATA,  8'h01, 1'b0, 1'b0, 6'h15, 1'b0, 1'b0, 1'b0, 1'b0},
      '{MODE_DATA,  8'h80, 1'b0, 1'b1, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{MODE_STOP,  8'h00, 1'b0, 1'b0, 6'h00, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   i2c_master_byte_writer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic void push_phase(input logic last, input logic nack);
      bus_phase_type ph;
      ph.scl  = line_scl;
      ph.sda  = line_sda;
      ph.nack = nack;
      ph.last = last;
      expected_phases.push_back(ph);
   endfunction

   // line sequence of one command, one entry per bus phase
   function automatic void predict_bus_phases(input logic [1:0] mode, input logic [7:0] data_val,
                                              input logic rw, input logic ack);
      logic [7:0] shift_val;
      case (mode)
         MODE_START: begin
            line_scl = 1'b1;
            push_phase(1'b0, 1'b0);
            line_sda = 1'b1;
            push_phase(1'b0, 1'b0);
            line_scl = 1'b0;
            push_phase(1'b1, 1'b0);
         end
         MODE_STOP: begin
            line_sda = 1'b1;
            push_phase(1'b0, 1'b0);
            line_scl = 1'b1;
            push_phase(1'b0, 1'b0);
            line_sda = 1'b0;
            push_phase(1'b1, 1'b0);
         end
         default: begin
            shift_val = (mode == MODE_ADDR) ? {data_val[7:1], rw} : data_val;
            for (int b = 7; b >= 0; b--) begin
               line_sda = ~shift_val[b];
               push_phase(1'b0, 1'b0);
               line_scl = 1'b1;
               push_phase(1'b0, 1'b0);
               line_scl = 1'b0;
               push_phase(1'b0, 1'b0);
            end
            // acknowledge clock with sda released
            line_sda = 1'b0;
            push_phase(1'b0, 1'b0);
            line_scl = 1'b1;
            push_phase(1'b0, 1'b0);
            line_scl = 1'b0;
            push_phase(1'b1, ack);
         end
      endcase
   endfunction

   task automatic send_command(input logic [1:0] mode, input logic [7:0] data_val,
                               input logic rw, input logic ack, input logic [PAD_W-1:0] pad,
                               input logic typed, input bus_phase_type typed_last);
      int gap;
      if (burst_left == 0) begin
         if (no_gap_left > 0)
            gap = 0;
         else if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(8, 20);
         else
            gap = $urandom_range(0, 4);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      if (no_gap_left > 0)
         no_gap_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {pad, ack, rw, data_val};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      predict_bus_phases(mode, data_val, rw, ack);
      if (typed)
         expected_phases[expected_phases.size() - 1] = typed_last;
      cmds_sent++;
      mode_count[mode]++;
      if (mode != MODE_START && mode != MODE_STOP && ack)
         nack_count++;
   endtask

   task automatic send_random(input logic [1:0] mode, input logic noisy);
      logic [PAD_W-1:0] pad;
      logic             ack;
      pad = noisy ? PAD_W'($urandom) : '0;
      ack = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
      send_command(mode, 8'($urandom), 1'($urandom_range(0, 1)), ack, pad, 1'b0, '0);
   endtask

   // result side: own stall pattern, plus one long hold-off on request
   initial begin : rsp_side
      int pat_cnt;
      int style;
      int hold_left;
      pat_cnt    = 0;
      style      = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && hold_left == 0) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (pat_cnt % 48 == 0)
               style = $urandom_range(0, 3);
            pat_cnt++;
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               2:       rsp_tready <= (pat_cnt % 5 != 0);
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      bus_phase_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_phases.size() == 0) begin
            $error("unexpected bus phase transfer: scl %0b sda %0b nack %0b last %0b",
                   rsp_tdata[0], rsp_tdata[1], rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_phases.pop_front();
            phases_checked++;
            if (rsp_tdata[0] !== want.scl) begin
               $error("scl_level: expected %0b, actual %0b", want.scl, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[1] !== want.sda) begin
               $error("sda_pull_low: expected %0b, actual %0b", want.sda, rsp_tdata[1]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.nack) begin
               $error("nack_error: expected %0b, actual %0b", want.nack, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_phase: expected %0b, actual %0b", want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      bus_phase_type typed_last;
      stim_row_type  row;
      bit            hold_done;
      int            wait_cycles;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = MODE_START;
      line_scl       = 1'b1;
      line_sda       = 1'b0;
      mismatch_count = 0;
      phases_checked = 0;
      cmds_sent      = 0;
      nack_count     = 0;
      burst_left     = 0;
      no_gap_left    = 0;
      long_hold_req  = 1'b0;
      hold_done      = 1'b0;
      foreach (mode_count[m])
         mode_count[m] = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         row = directed_rows[r];
         typed_last.scl  = row.t_scl;
         typed_last.sda  = row.t_sda;
         typed_last.nack = row.t_nack;
         typed_last.last = 1'b1;
         send_command(row.mode, row.data_val, row.rw, row.ack, row.pad, row.typed, typed_last);
      end

      while (cmds_sent < NUM_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 8) begin
            // well-formed transaction with random content
            send_random(MODE_START, 1'b0);
            send_random(MODE_ADDR, 1'b0);
            repeat ($urandom_range(1, 4)) send_random(MODE_DATA, 1'b0);
            send_random(MODE_STOP, 1'b0);
         end else begin
            repeat ($urandom_range(1, 3)) send_random(2'($urandom_range(0, 3)), 1'b1);
         end
         if (!hold_done && cmds_sent >= NUM_ROWS + 50) begin
            // receiver holds off while commands keep coming back to back
            hold_done     = 1'b1;
            long_hold_req = 1'b1;
            no_gap_left   = 8;
            burst_left    = 0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (expected_phases.size() != 0) begin
         @(posedge clock);
      end
      while (wait_cycles < SETTLE) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_phases.size() != 0) begin
         $error("%0d expected bus phases never arrived", expected_phases.size());
         mismatch_count++;
      end

      $display("covered %0d commands: %0d start, %0d address, %0d data, %0d stop",
               cmds_sent, mode_count[MODE_START], mode_count[MODE_ADDR],
               mode_count[MODE_DATA], mode_count[MODE_STOP]);
      $display("checked %0d bus phases, %0d bytes not acknowledged", phases_checked, nack_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
